// ===== hw/rtl/midpoint_ellipse_raster_assert.svh =====
// Assertion macros used by the checker file mer_checker.sv.
`ifndef MIDPOINT_ELLIPSE_RASTER_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTER_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define MER_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("midpoint_ellipse_raster: property violated");

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define MER_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("midpoint_ellipse_raster: property violated");

`endif

// ===== hw/rtl/mer_pkg.sv =====
package mer_pkg;

  localparam int COORD_BITS  = 11;
  localparam int RADIUS_BITS = 10;

  localparam int SQ_BITS   = 2 * RADIUS_BITS;
  localparam int STEP_BITS = RADIUS_BITS + 2;
  localparam int MUL_BITS  = 2 * RADIUS_BITS + 4;
  localparam int PROD_BITS = 2 * MUL_BITS;
  localparam int DEC_BITS  = 48;
  localparam int PIX_BITS  = 13;

  localparam int IN_FIELD_BITS = 2 * COORD_BITS + 2 * RADIUS_BITS;
  localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((2 * PIX_BITS + 7) / 8) * 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam int PIX_PER_POINT = 4;
  localparam int PIX_CNT_BITS  = $clog2(PIX_PER_POINT);

  // action field codes
  localparam logic ACT_ADVANCE = 1'b0;
  localparam logic ACT_START   = 1'b1;

  typedef struct packed {
    logic                   start;
    logic [COORD_BITS-1:0]  cx;
    logic [COORD_BITS-1:0]  cy;
    logic [RADIUS_BITS-1:0] rx;
    logic [RADIUS_BITS-1:0] ry;
  } mer_cmd_t;

  typedef struct packed {
    logic signed [STEP_BITS-1:0] x;
    logic signed [STEP_BITS-1:0] y;
    logic [COORD_BITS-1:0]       cx;
    logic [COORD_BITS-1:0]       cy;
    logic                        final_pt;
  } mer_point_t;

endpackage

// ===== hw/rtl/mer_front.sv =====
module mer_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [mer_pkg::IN_DATA_BITS-1:0] s_axis_tdata_i,
  input  logic                             s_axis_tuser_i,
  output logic                             q_valid_o,
  output mer_pkg::mer_cmd_t                q_cmd_o,
  input  logic                             q_pop_i
);
  import mer_pkg::*;

  mer_cmd_t entry_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_q, rd_q;
  logic [QCNT_BITS-1:0] cnt_q;
  mer_cmd_t in_cmd;
  logic push, pop;

  always_comb begin
    in_cmd.start = (s_axis_tuser_i == ACT_START);
    in_cmd.cx    = s_axis_tdata_i[COORD_BITS-1:0];
    in_cmd.cy    = s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS];
    in_cmd.rx    = s_axis_tdata_i[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS];
    in_cmd.ry    = s_axis_tdata_i[IN_FIELD_BITS-1:2*COORD_BITS+RADIUS_BITS];
  end

  assign s_axis_tready_o = (cnt_q != QCNT_BITS'(QUEUE_DEPTH));
  assign q_valid_o       = (cnt_q != '0);
  assign q_cmd_o         = entry_q[rd_q];
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = q_pop_i && q_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= in_cmd;
    end
  end

endmodule

// ===== hw/rtl/mer_engine.sv =====
module mer_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  mer_pkg::mer_cmd_t   q_cmd_i,
  output logic                q_pop_o,
  input  logic                em_can_load_i,
  output logic                em_load_o,
  output mer_pkg::mer_point_t em_point_o
);
  import mer_pkg::*;

  localparam logic [2:0] ST_READY = 3'd0;
  localparam logic [2:0] ST_PROD  = 3'd1;
  localparam logic [2:0] ST_INIT  = 3'd2;
  localparam logic [2:0] ST_CHK   = 3'd3;
  localparam logic [2:0] ST_SQ    = 3'd4;
  localparam logic [2:0] ST_D2    = 3'd5;
  localparam logic [2:0] ST_ADV   = 3'd6;

  localparam logic signed [MUL_BITS-1:0]  C_ONE   = MUL_BITS'(1);
  localparam logic signed [MUL_BITS-1:0]  C_TWO   = MUL_BITS'(2);
  localparam logic signed [MUL_BITS-1:0]  C_THREE = MUL_BITS'(3);
  localparam logic signed [STEP_BITS-1:0] S_ONE   = STEP_BITS'(1);

  logic [2:0] state_q, state_d;
  logic busy_q, busy_d, pend_q, pend_d, r2_q, r2_d;

  logic [COORD_BITS-1:0]       cx_q, cx_d, cy_q, cy_d;
  logic [RADIUS_BITS-1:0]      ry_q, ry_d;
  logic [SQ_BITS-1:0]          rx_sq_q, rx_sq_d, ry_sq_q, ry_sq_d;
  logic signed [DEC_BITS-1:0]  sq_prod_q, sq_prod_d;
  logic signed [STEP_BITS-1:0] x_q, x_d, y_q, y_d;
  logic signed [DEC_BITS-1:0]  d1_q, d1_d, d2_q, d2_d;
  logic signed [DEC_BITS-1:0]  p0_q, p1_q;

  logic signed [MUL_BITS-1:0]  ma0, mb0, ma1, mb1;
  logic signed [PROD_BITS-1:0] prod0, prod1;

  logic signed [MUL_BITS-1:0] rxsq_m, rysq_m, x_m, y_m, ry_m, p0_m, p1_m;
  logic signed [MUL_BITS-1:0] qrx_m, qry_m, k2x3, k3m2y, k2p2x, ynew_m;
  logic signed [DEC_BITS-1:0] rysq_w, rxsq_qtr, rysq_qtr;
  logic final_now, take_point;

  assign rxsq_m = MUL_BITS'($signed({1'b0, rx_sq_q}));
  assign rysq_m = MUL_BITS'($signed({1'b0, ry_sq_q}));
  assign x_m    = MUL_BITS'(x_q);
  assign y_m    = MUL_BITS'(y_q);
  assign ry_m   = MUL_BITS'($signed({1'b0, ry_q}));
  assign p0_m   = MUL_BITS'(p0_q);
  assign p1_m   = MUL_BITS'(p1_q);
  assign qrx_m  = MUL_BITS'($signed({1'b0, q_cmd_i.rx}));
  assign qry_m  = MUL_BITS'($signed({1'b0, q_cmd_i.ry}));
  assign k2x3   = (x_m <<< 1) + C_THREE;
  assign k3m2y  = C_THREE - (y_m <<< 1);
  assign k2p2x  = C_TWO + (x_m <<< 1);
  // y after the region-one step, chosen by the sign of the old decision
  assign ynew_m = d1_q[DEC_BITS-1] ? y_m : y_m - C_ONE;

  assign rysq_w   = DEC_BITS'($signed({1'b0, ry_sq_q}));
  assign rxsq_qtr = DEC_BITS'($signed({3'b000, rx_sq_q[SQ_BITS-1:2]}));
  assign rysq_qtr = DEC_BITS'($signed({3'b000, ry_sq_q[SQ_BITS-1:2]}));

  assign final_now = r2_q && (y_q == '0);

  assign em_point_o.x        = x_q;
  assign em_point_o.y        = y_q;
  assign em_point_o.cx       = cx_q;
  assign em_point_o.cy       = cy_q;
  assign em_point_o.final_pt = final_now;

  assign prod0 = ma0 * mb0;
  assign prod1 = ma1 * mb1;

  always_comb begin
    state_d   = state_q;
    busy_d    = busy_q;
    pend_d    = pend_q;
    r2_d      = r2_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    ry_d      = ry_q;
    rx_sq_d   = rx_sq_q;
    ry_sq_d   = ry_sq_q;
    sq_prod_d = sq_prod_q;
    x_d       = x_q;
    y_d       = y_q;
    d1_d      = d1_q;
    d2_d      = d2_q;
    q_pop_o   = 1'b0;
    em_load_o = 1'b0;
    take_point = 1'b0;
    // advance products by default, issued while a point is handed out
    ma0 = rysq_m;
    mb0 = r2_q ? k2p2x : k2x3;
    ma1 = rxsq_m;
    mb1 = k3m2y;

    unique case (state_q)
      ST_READY: begin
        if (pend_q) begin
          take_point = em_can_load_i;
          if (em_can_load_i) begin
            pend_d = 1'b0;
          end
        end else if (q_valid_i) begin
          if (q_cmd_i.start) begin
            q_pop_o = 1'b1;
            cx_d    = q_cmd_i.cx;
            cy_d    = q_cmd_i.cy;
            ry_d    = q_cmd_i.ry;
            busy_d  = 1'b1;
            pend_d  = 1'b1;
            ma0     = qrx_m;
            mb0     = qrx_m;
            ma1     = qry_m;
            mb1     = qry_m;
            state_d = ST_PROD;
          end else if (!busy_q) begin
            q_pop_o = 1'b1;
          end else if (em_can_load_i) begin
            q_pop_o    = 1'b1;
            take_point = 1'b1;
          end
        end
        if (take_point) begin
          em_load_o = 1'b1;
          if (final_now) begin
            busy_d = 1'b0;
          end else begin
            state_d = ST_ADV;
          end
        end
      end
      ST_PROD: begin
        rx_sq_d = p0_q[SQ_BITS-1:0];
        ry_sq_d = p1_q[SQ_BITS-1:0];
        ma0     = p0_m;
        mb0     = p1_m;
        ma1     = p0_m;
        mb1     = ry_m;
        state_d = ST_INIT;
      end
      ST_INIT: begin
        sq_prod_d = p0_q;
        d1_d      = rysq_w - p1_q + rxsq_qtr;
        d2_d      = '0;
        x_d       = '0;
        y_d       = STEP_BITS'($signed({1'b0, ry_q}));
        r2_d      = 1'b0;
        ma0       = '0;
        mb0       = rysq_m;
        ma1       = ry_m;
        mb1       = rxsq_m;
        state_d   = ST_CHK;
      end
      ST_CHK: begin
        // region one holds while x*ry^2 < y*rx^2
        ma0 = x_m;
        mb0 = x_m + C_ONE;
        ma1 = y_m - C_ONE;
        mb1 = y_m - C_ONE;
        if (p0_q < p1_q) begin
          state_d = ST_READY;
        end else begin
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        ma0     = rysq_m;
        mb0     = p0_m;
        ma1     = rxsq_m;
        mb1     = p1_m;
        state_d = ST_D2;
      end
      ST_D2: begin
        d2_d    = p0_q + rysq_qtr + p1_q - sq_prod_q;
        r2_d    = 1'b1;
        state_d = ST_READY;
      end
      ST_ADV: begin
        if (!r2_q) begin
          if (d1_q[DEC_BITS-1]) begin
            d1_d = d1_q + p0_q;
          end else begin
            d1_d = d1_q + p0_q + p1_q;
          end
          x_d     = x_q + S_ONE;
          y_d     = STEP_BITS'(ynew_m);
          ma0     = x_m + C_ONE;
          mb0     = rysq_m;
          ma1     = ynew_m;
          mb1     = rxsq_m;
          state_d = ST_CHK;
        end else begin
          if (d2_q[DEC_BITS-1]) begin
            d2_d = d2_q + p1_q + p0_q;
            x_d  = x_q + S_ONE;
          end else begin
            d2_d = d2_q + p1_q;
          end
          y_d     = y_q - S_ONE;
          state_d = ST_READY;
        end
      end
      default: begin
        state_d = ST_READY;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_READY;
      busy_q  <= 1'b0;
      pend_q  <= 1'b0;
      r2_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      pend_q  <= pend_d;
      r2_q    <= r2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    ry_q      <= ry_d;
    rx_sq_q   <= rx_sq_d;
    ry_sq_q   <= ry_sq_d;
    sq_prod_q <= sq_prod_d;
    x_q       <= x_d;
    y_q       <= y_d;
    d1_q      <= d1_d;
    d2_q      <= d2_d;
    p0_q      <= DEC_BITS'(prod0);
    p1_q      <= DEC_BITS'(prod1);
  end

endmodule

// ===== hw/rtl/mer_emit.sv =====
module mer_emit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              em_load_i,
  input  mer_pkg::mer_point_t               em_point_i,
  output logic                              em_can_load_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [mer_pkg::OUT_DATA_BITS-1:0] m_axis_tdata_o,
  output logic                              m_axis_tlast_o,
  output logic                              m_axis_tuser_o
);
  import mer_pkg::*;

  localparam logic [PIX_CNT_BITS-1:0] LAST_PIX = PIX_CNT_BITS'(PIX_PER_POINT - 1);

  mer_point_t pt_q;
  logic vld_q;
  logic [PIX_CNT_BITS-1:0] cnt_q;
  logic [PIX_BITS-1:0] cx_p, cy_p, x_p, y_p, px, py;

  assign em_can_load_o = !vld_q || (m_axis_tready_i && (cnt_q == LAST_PIX));

  assign cx_p = PIX_BITS'({1'b0, pt_q.cx});
  assign cy_p = PIX_BITS'({1'b0, pt_q.cy});
  assign x_p  = PIX_BITS'(pt_q.x);
  assign y_p  = PIX_BITS'(pt_q.y);
  // pixel order: (+x,+y) (-x,+y) (+x,-y) (-x,-y)
  assign px   = cnt_q[0] ? cx_p - x_p : cx_p + x_p;
  assign py   = cnt_q[1] ? cy_p - y_p : cy_p + y_p;

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = OUT_DATA_BITS'({py, px});
  assign m_axis_tlast_o  = (cnt_q == LAST_PIX);
  assign m_axis_tuser_o  = pt_q.final_pt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cnt_q <= '0;
    end else if (em_load_i) begin
      vld_q <= 1'b1;
      cnt_q <= '0;
    end else if (vld_q && m_axis_tready_i) begin
      if (cnt_q == LAST_PIX) begin
        vld_q <= 1'b0;
      end
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (em_load_i) begin
      pt_q <= em_point_i;
    end
  end

endmodule

// ===== hw/rtl/midpoint_ellipse_raster.sv =====
// Channel  | dir | tdata, lowest bit up                      | tuser         | tlast
// s_axis   | in  | center_x 11, center_y 11, radius_x 10,    | action        | -
//          |     | radius_y 10, zero pad to 48               |               |
// m_axis   | out | pixel_x 13, pixel_y 13, zero pad to 32    | final_point   | last_of_point
//
// A 2-entry input queue feeds an arithmetic sequencer with two 24x24 multipliers.
// Advance: the sequencer works on the next point while the emitter sends 4 pixels;
// it steps READY, ADV in region two, READY, ADV, CHK in region one, and SQ, D2 on
// the switch. Start: squares, products, first region test (PROD, INIT, CHK), and
// SQ, D2 if the first point already lies in region two; it then loads into the emitter.
// Reset (async, active low) leaves it idle; a stalled output backs up the queue.
module midpoint_ellipse_raster (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // center_x, center_y, radius_x, radius_y, zero pad
  input  logic [mer_pkg::IN_DATA_BITS-1:0]  s_axis_tdata_i,
  // action
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // pixel_x, pixel_y, zero pad
  output logic [mer_pkg::OUT_DATA_BITS-1:0] m_axis_tdata_o,
  // last_of_point
  output logic                              m_axis_tlast_o,
  // final_point
  output logic                              m_axis_tuser_o
);
  import mer_pkg::*;

  logic       q_valid, q_pop, em_can_load, em_load;
  mer_cmd_t   q_cmd;
  mer_point_t em_point;

  mer_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_valid_o       (q_valid),
    .q_cmd_o         (q_cmd),
    .q_pop_i         (q_pop)
  );

  mer_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_cmd_i       (q_cmd),
    .q_pop_o       (q_pop),
    .em_can_load_i (em_can_load),
    .em_load_o     (em_load),
    .em_point_o    (em_point)
  );

  mer_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .em_load_i       (em_load),
    .em_point_i      (em_point),
    .em_can_load_o   (em_can_load),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

// ===== hw/rtl/mer_checker.sv =====
`include "midpoint_ellipse_raster_assert.svh"

module mer_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [mer_pkg::OUT_DATA_BITS-1:0] m_axis_tdata_o,
  input logic                              m_axis_tlast_o,
  input logic                              m_axis_tuser_o
);
  import mer_pkg::*;

  localparam logic [PIX_CNT_BITS-1:0] LAST_PIX = PIX_CNT_BITS'(PIX_PER_POINT - 1);
  localparam logic [PIX_CNT_BITS-1:0] MIRROR_X = PIX_CNT_BITS'(1);

  logic [PIX_CNT_BITS-1:0] cnt_q;
  logic [PIX_BITS-1:0]     prev_y_q;
  logic                    prev_user_q;
  logic [PIX_BITS-1:0]     cur_y;

  assign cur_y = m_axis_tdata_o[2*PIX_BITS-1:PIX_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      prev_y_q    <= '0;
      prev_user_q <= 1'b0;
    end else if (m_axis_tvalid_o && m_axis_tready_i) begin
      cnt_q       <= cnt_q + 1'b1;
      prev_y_q    <= cur_y;
      prev_user_q <= m_axis_tuser_o;
    end
  end

  `MER_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))
  `MER_ASSERT_IMP(a_last_on_fourth, m_axis_tvalid_o, m_axis_tlast_o == (cnt_q == LAST_PIX))
  `MER_ASSERT_IMP(a_mirror_row, m_axis_tvalid_o && (cnt_q == MIRROR_X), cur_y == prev_y_q)
  `MER_ASSERT_IMP(a_final_steady, m_axis_tvalid_o && (cnt_q != '0), m_axis_tuser_o == prev_user_q)

endmodule

bind midpoint_ellipse_raster mer_checker u_mer_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== sim/testbench.sv =====
module testbench;
  import mer_pkg::*;

  typedef struct {
    logic [PIX_BITS-1:0] pixel_x;
    logic [PIX_BITS-1:0] pixel_y;
    logic                last_of_point;
    logic                final_point;
  } ellipse_pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                     s_valid = 1'b0;
  logic                     s_ready;
  logic [IN_DATA_BITS-1:0]  s_data = '0;
  logic                     s_action = ACT_ADVANCE;
  logic                     m_valid;
  logic                     m_ready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_data;
  logic                     m_last;
  logic                     m_final;

  always #1 clk_i = ~clk_i;

  midpoint_ellipse_raster dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_action),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .m_axis_tuser_o  (m_final)
  );

  // Predicted tracer state
  logic [COORD_BITS-1:0]      trc_cx, trc_cy;
  logic [SQ_BITS-1:0]         trc_rx2, trc_ry2;
  logic [2*SQ_BITS-1:0]       trc_rr;
  logic signed [STEP_BITS-1:0] trc_x, trc_y;
  logic signed [DEC_BITS-1:0] trc_d1, trc_d2;
  bit                         trc_region2;
  bit                         trc_busy;

  ellipse_pixel_t pixel_queue[$];

  int fail_count;
  int active_items;
  int idle_advances;
  int ellipses_started;
  int ellipses_done;
  int pixels_checked;

  // sender burst shaping
  int burst_left;
  int gap_max;

  // receiver hold-off request, serviced by the receiver process
  bit hold_request;
  int hold_cycles_seen;

  // Switch to region two once x*ry^2 >= y*rx^2; seed its decision value.
  task automatic update_region();
    longint x, y, rx2, ry2, rr;
    x = longint'(trc_x);
    y = longint'(trc_y);
    rx2 = longint'(trc_rx2);
    ry2 = longint'(trc_ry2);
    rr = longint'(trc_rr);
    if (!trc_region2 && x * ry2 >= y * rx2) begin
      trc_region2 = 1'b1;
      trc_d2 = DEC_BITS'(ry2 * (x * x + x) + (ry2 >> 2) + rx2 * (y * y + 1 - 2 * y) - rr);
    end
  endtask

  task automatic predict_ellipse_pixels(input logic act, input logic [COORD_BITS-1:0] cx,
                                        input logic [COORD_BITS-1:0] cy,
                                        input logic [RADIUS_BITS-1:0] rx,
                                        input logic [RADIUS_BITS-1:0] ry);
    longint x, y, rx2, ry2, pcx, pcy, px, py, rys;
    bit done;
    ellipse_pixel_t pix;
    if (act == ACT_START) begin
      trc_cx = cx;
      trc_cy = cy;
      trc_rx2 = rx * rx;
      trc_ry2 = ry * ry;
      trc_rr = trc_rx2 * trc_ry2;
      rx2 = longint'(trc_rx2);
      ry2 = longint'(trc_ry2);
      rys = longint'(ry);
      trc_d1 = DEC_BITS'(ry2 - rx2 * rys + (rx2 >> 2));
      trc_d2 = '0;
      trc_x = '0;
      trc_y = STEP_BITS'(ry);
      trc_region2 = 1'b0;
      trc_busy = 1'b1;
      ellipses_started++;
      update_region();
    end else if (!trc_busy) begin
      idle_advances++;
      return;
    end
    active_items++;
    x = longint'(trc_x);
    y = longint'(trc_y);
    rx2 = longint'(trc_rx2);
    ry2 = longint'(trc_ry2);
    pcx = longint'(trc_cx);
    pcy = longint'(trc_cy);
    done = 1'b0;
    if (!trc_region2) begin
      if (trc_d1 < 0) begin
        trc_d1 = DEC_BITS'(trc_d1 + ry2 * (2 * x + 3));
      end else begin
        trc_d1 = DEC_BITS'(trc_d1 + ry2 * (2 * x + 3) + rx2 * (3 - 2 * y));
        trc_y = STEP_BITS'(y - 1);
      end
      trc_x = STEP_BITS'(x + 1);
      update_region();
    end else begin
      if (trc_d2 < 0) begin
        trc_d2 = DEC_BITS'(trc_d2 + rx2 * (3 - 2 * y) + ry2 * (2 + 2 * x));
        trc_x = STEP_BITS'(x + 1);
      end else begin
        trc_d2 = DEC_BITS'(trc_d2 + rx2 * (3 - 2 * y));
      end
      trc_y = STEP_BITS'(y - 1);
      done = (y - 1 < 0);
    end
    if (done) begin
      trc_busy = 1'b0;
      ellipses_done++;
    end
    // four mirrored pixels: (+x,+y) (-x,+y) (+x,-y) (-x,-y)
    for (int k = 0; k < PIX_PER_POINT; k++) begin
      px = k[0] ? pcx - x : pcx + x;
      py = k[1] ? pcy - y : pcy + y;
      pix.pixel_x = PIX_BITS'(px);
      pix.pixel_y = PIX_BITS'(py);
      pix.last_of_point = (k == PIX_PER_POINT - 1);
      pix.final_point = done;
      pixel_queue.push_back(pix);
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic act, input logic [COORD_BITS-1:0] cx,
                           input logic [COORD_BITS-1:0] cy,
                           input logic [RADIUS_BITS-1:0] rx,
                           input logic [RADIUS_BITS-1:0] ry);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_max > 0) gap = $urandom_range(1, gap_max);
    end
    burst_left--;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_data <= {{(IN_DATA_BITS - IN_FIELD_BITS){1'b0}}, ry, rx, cy, cx};
    s_action <= act;
    s_valid <= 1'b1;
    do @(posedge clk_i); while (!s_ready);
    predict_ellipse_pixels(act, cx, cy, rx, ry);
    @(negedge clk_i);
  endtask

  // advance with junk in the unused fields
  task automatic send_advance();
    send_item(ACT_ADVANCE, COORD_BITS'($urandom_range(0, 2047)),
              COORD_BITS'($urandom_range(0, 2047)),
              RADIUS_BITS'($urandom_range(0, 1023)),
              RADIUS_BITS'($urandom_range(0, 1023)));
  endtask

  task automatic run_to_end(input int max_points);
    int n;
    n = max_points;
    while (trc_busy && n > 0) begin
      send_advance();
      n--;
    end
  endtask

  task automatic test_idle_advance();
    gap_max = 0;
    send_advance();
    send_advance();
  endtask

  task automatic test_degenerate_radii();
    gap_max = 2;
    // both radii zero: one point, final at once
    send_item(ACT_START, 11'd2047, 11'd2047, 10'd0, 10'd0);
    send_advance();
    // no region one when ry is zero
    send_item(ACT_START, 11'd0, 11'd0, 10'd1023, 10'd0);
    // tall, zero width: region two only
    send_item(ACT_START, 11'd2047, 11'd0, 10'd0, 10'd2);
    run_to_end(10);
  endtask

  task automatic test_restart_while_busy();
    gap_max = 3;
    send_item(ACT_START, 11'd0, 11'd2047, 10'd1023, 10'd1023);
    repeat (4) send_advance();
    send_item(ACT_START, 11'd1024, 11'd5, 10'd4, 10'd3);
    run_to_end(20);
  endtask

  task automatic test_output_hold();
    gap_max = 0;
    send_item(ACT_START, 11'd600, 11'd700, 10'd200, 10'd150);
    hold_request = 1'b1;
    repeat (40) send_advance();
  endtask

  task automatic test_random_ellipses();
    int target, kind, n_adv;
    logic [RADIUS_BITS-1:0] rx, ry;
    target = active_items + 500;
    while (active_items < target) begin
      kind = $urandom_range(0, 99);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (kind < 8) begin
        repeat ($urandom_range(1, 3)) send_advance();
      end else begin
        if (kind < 18) begin
          rx = RADIUS_BITS'($urandom_range(0, 1023));
          ry = RADIUS_BITS'($urandom_range(0, 1023));
          n_adv = $urandom_range(3, 30);
        end else begin
          rx = RADIUS_BITS'($urandom_range(0, (kind < 50) ? 6 : 24));
          ry = RADIUS_BITS'($urandom_range(0, (kind < 50) ? 6 : 24));
          n_adv = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 8) : 100000;
        end
        send_item(ACT_START, COORD_BITS'($urandom_range(0, 2047)),
                  COORD_BITS'($urandom_range(0, 2047)), rx, ry);
        run_to_end(n_adv);
      end
    end
  endtask

  // receiver: occasional long hold-off, otherwise a changing stall pattern
  initial begin
    int hold_left, age, mode, phase;
    logic [7:0] pattern;
    hold_left = 0;
    age = 0;
    mode = 0;
    phase = 0;
    pattern = '1;
    forever begin
      @(negedge clk_i);
      if (hold_request && hold_left == 0) begin
        hold_request = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        hold_cycles_seen++;
        m_ready <= 1'b0;
      end else begin
        if (age == 0) begin
          age = $urandom_range(16, 128);
          mode = $urandom_range(0, 3);
          pattern = 8'($urandom);
        end
        age--;
        phase++;
        unique case (mode)
          0: m_ready <= 1'b1;
          1: m_ready <= pattern[phase % 8];
          2: m_ready <= 1'($urandom_range(0, 1));
          default: m_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // pixel checker
  always @(posedge clk_i) begin
    ellipse_pixel_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (pixel_queue.size() == 0) begin
        fail_count++;
        if (fail_count <= 50)
          $display("%0t: unexpected pixel x=%0d y=%0d last=%0b final=%0b", $time,
                   $signed(m_data[PIX_BITS-1:0]), $signed(m_data[2*PIX_BITS-1:PIX_BITS]),
                   m_last, m_final);
      end else begin
        want = pixel_queue.pop_front();
        pixels_checked++;
        if (want.pixel_x !== m_data[PIX_BITS-1:0] ||
            want.pixel_y !== m_data[2*PIX_BITS-1:PIX_BITS] ||
            want.last_of_point !== m_last || want.final_point !== m_final) begin
          fail_count++;
          if (fail_count <= 50)
            $display(
              "%0t: mismatch exp %0d,%0d last %0b final %0b, got %0d,%0d last %0b final %0b",
              $time, $signed(want.pixel_x), $signed(want.pixel_y),
              want.last_of_point, want.final_point,
              $signed(m_data[PIX_BITS-1:0]), $signed(m_data[2*PIX_BITS-1:PIX_BITS]),
              m_last, m_final);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    trc_cx = '0;
    trc_cy = '0;
    trc_rx2 = '0;
    trc_ry2 = '0;
    trc_rr = '0;
    trc_x = '0;
    trc_y = '0;
    trc_d1 = '0;
    trc_d2 = '0;
    trc_region2 = 1'b0;
    trc_busy = 1'b0;
    burst_left = 0;
    gap_max = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_idle_advance();
    test_degenerate_radii();
    test_restart_while_busy();
    test_output_hold();
    test_random_ellipses();
    s_valid <= 1'b0;

    while (pixel_queue.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("covered %0d ellipses (%0d run to the end), %0d drawing items, %0d idle advances",
             ellipses_started, ellipses_done, active_items, idle_advances);
    $display("checked %0d pixels, output held off for %0d cycles", pixels_checked,
             hold_cycles_seen);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/mer_pkg.sv
hw/rtl/mer_front.sv
hw/rtl/mer_engine.sv
hw/rtl/mer_emit.sv
hw/rtl/midpoint_ellipse_raster.sv
hw/rtl/mer_checker.sv
sim/testbench.sv
